// ----- rtl/sorted_position_table_insert_assert.svh -----
// assertion helpers for the sorted position table checker
`ifndef SORTED_POSITION_TABLE_INSERT_ASSERT_SVH
`define SORTED_POSITION_TABLE_INSERT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SPTBL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SPTBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sptbl_pkg.sv -----
package sptbl_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int POS_WIDTH   = 23;
    localparam int BASE_W      = 2;
    localparam int OP_W        = 2;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W     = POS_WIDTH + BASE_W;

    localparam int S_FIELDS_W  = POS_WIDTH + BASE_W + IDX_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = IDX_W + POS_WIDTH + BASE_W + 1 + CNT_W + 1 + 1;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan;
        logic finish;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/sorted_position_table_insert.sv -----
// Sorted position table: holds up to 64 (position, base) entries in ascending
// position order in a simple dual-port table memory (one write and one
// registered read per cycle). Each item carries an operation in s_tuser and
// gives exactly one result item. An insert sweeps the table from slot 0, one
// entry per cycle, updating a matching entry in place or rippling larger
// entries up by one behind the new one; the sweep stops early at a matching
// entry, or at a larger one when the table is full and the insert is dropped.
// A read passes an issue state for its registered table read. One item is in
// work at a time; the result register lets the next item be accepted while a
// result waits. Table contents are not cleared after reset: only slots below
// the count are ever returned, and a clear just zeroes the count.
module sorted_position_table_insert (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // position[22:0], base[24:23], read_index[30:25], zero fill
    input  logic [sptbl_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [sptbl_pkg::OP_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot[5:0], entry_position[28:6], entry_base[30:29], entry_valid[31],
    // entry_count[38:32], was_update[39], dropped[40], zero fill
    output logic [sptbl_pkg::M_TDATA_W-1:0] m_tdata
);

    sptbl_pkg::cmd_t cmd;
    sptbl_pkg::sts_t sts;

    sptbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sptbl_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_op     (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/sptbl_ctrl.sv -----
module sptbl_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic [sptbl_pkg::OP_W-1:0] s_op,
    output logic                       s_tready,
    output sptbl_pkg::cmd_t            cmd,
    input  sptbl_pkg::sts_t            sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_RD_ISSUE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    case (sptbl_pkg::op_t'(s_op))
                        sptbl_pkg::OP_INSERT: state_next = ST_SCAN;
                        sptbl_pkg::OP_READ:   state_next = ST_RD_ISSUE;
                        default:              state_next = ST_EMIT;
                    endcase
                end
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_RD_ISSUE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/sptbl_dp.sv -----
module sptbl_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sptbl_pkg::cmd_t                 cmd,
    output sptbl_pkg::sts_t                 sts,
    input  logic [sptbl_pkg::OP_W-1:0]      s_op,
    input  logic [sptbl_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sptbl_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int POS_W = sptbl_pkg::POS_WIDTH;
    localparam int BW    = sptbl_pkg::BASE_W;
    localparam int IW    = sptbl_pkg::IDX_W;
    localparam int CW    = sptbl_pkg::CNT_W;
    localparam int EW    = sptbl_pkg::ENTRY_W;
    localparam int PAD_W = sptbl_pkg::M_TDATA_W - sptbl_pkg::M_FIELDS_W;

    // entries are packed {key, base}
    logic [EW-1:0] entry_mem [sptbl_pkg::MAX_ENTRIES];
    logic [EW-1:0] rdata_reg;

    sptbl_pkg::op_t op_reg, op_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [BW-1:0]    base_reg, base_next;
    logic [IW-1:0]    ridx_reg, ridx_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic [IW-1:0]    chk_idx_reg, chk_idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             ins_reg, ins_next;
    logic             stop_reg, stop_next;
    logic [EW-1:0]    carry_reg, carry_next;
    logic [IW-1:0]    slot_reg, slot_next;
    logic             upd_reg, upd_next;
    logic             drop_reg, drop_next;

    logic             out_valid_reg, out_valid_next;
    logic [IW-1:0]    out_slot_reg, out_slot_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;
    logic [BW-1:0]    out_base_reg, out_base_next;
    logic             out_evalid_reg, out_evalid_next;
    logic [CW-1:0]    out_count_reg, out_count_next;
    logic             out_upd_reg, out_upd_next;
    logic             out_drop_reg, out_drop_next;

    logic             we;
    logic [IW-1:0]    waddr;
    logic [EW-1:0]    wdata;
    logic [IW-1:0]    raddr;
    logic [POS_W-1:0] rd_key;
    logic [EW-1:0]    new_entry;
    logic             full;
    logic             rd_hit;

    assign rd_key    = rdata_reg[EW-1:BW];
    assign new_entry = {pos_reg, base_reg};
    assign full      = (count_reg == CW'(sptbl_pkg::MAX_ENTRIES));
    assign raddr     = (op_reg == sptbl_pkg::OP_READ) ? ridx_reg : rd_idx_reg[IW-1:0];
    assign rd_hit    = (op_reg == sptbl_pkg::OP_READ)
                       && ({{(CW-IW){1'b0}}, ridx_reg} < count_reg);

    assign sts.scan_done = stop_reg || (!chk_vld_reg && (rd_idx_reg == count_reg));
    assign sts.out_free  = !out_valid_reg || m_tready;

    always_comb begin
        op_next         = op_reg;
        pos_next        = pos_reg;
        base_next       = base_reg;
        ridx_next       = ridx_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        ins_next        = ins_reg;
        stop_next       = stop_reg;
        carry_next      = carry_reg;
        slot_next       = slot_reg;
        upd_next        = upd_reg;
        drop_next       = drop_reg;
        we              = 1'b0;
        waddr           = chk_idx_reg;
        wdata           = new_entry;
        out_valid_next  = out_valid_reg;
        out_slot_next   = out_slot_reg;
        out_pos_next    = out_pos_reg;
        out_base_next   = out_base_reg;
        out_evalid_next = out_evalid_reg;
        out_count_next  = out_count_reg;
        out_upd_next    = out_upd_reg;
        out_drop_next   = out_drop_reg;

        if (cmd.capture) begin
            op_next      = sptbl_pkg::op_t'(s_op);
            pos_next     = s_tdata[POS_W-1:0];
            base_next    = s_tdata[POS_W +: BW];
            ridx_next    = s_tdata[POS_W+BW +: IW];
            rd_idx_next  = '0;
            chk_vld_next = 1'b0;
            ins_next     = 1'b0;
            stop_next    = 1'b0;
            slot_next    = '0;
            upd_next     = 1'b0;
            drop_next    = 1'b0;
            if (sptbl_pkg::op_t'(s_op) == sptbl_pkg::OP_CLEAR) begin
                count_next = '0;
            end
        end

        if (cmd.scan) begin
            // read one entry ahead, check the entry read last cycle
            if (rd_idx_reg < count_reg) begin
                rd_idx_next  = rd_idx_reg + CW'(1);
                chk_vld_next = 1'b1;
                chk_idx_next = rd_idx_reg[IW-1:0];
            end else begin
                chk_vld_next = 1'b0;
            end
            if (chk_vld_reg) begin
                if (ins_reg) begin
                    // ripple the displaced entry up one slot
                    we         = 1'b1;
                    wdata      = carry_reg;
                    carry_next = rdata_reg;
                end else if (rd_key == pos_reg) begin
                    we        = 1'b1;
                    slot_next = chk_idx_reg;
                    upd_next  = 1'b1;
                    stop_next = 1'b1;
                end else if (rd_key > pos_reg) begin
                    if (full) begin
                        drop_next = 1'b1;
                        stop_next = 1'b1;
                    end else begin
                        we         = 1'b1;
                        slot_next  = chk_idx_reg;
                        ins_next   = 1'b1;
                        carry_next = rdata_reg;
                    end
                end
            end
        end

        if (cmd.finish && !stop_reg) begin
            if (ins_reg) begin
                we         = 1'b1;
                waddr      = count_reg[IW-1:0];
                wdata      = carry_reg;
                count_next = count_reg + CW'(1);
            end else if (full) begin
                drop_next = 1'b1;
            end else begin
                we         = 1'b1;
                waddr      = count_reg[IW-1:0];
                slot_next  = count_reg[IW-1:0];
                count_next = count_reg + CW'(1);
            end
        end

        if (cmd.emit) begin
            out_valid_next  = 1'b1;
            out_count_next  = count_reg;
            out_evalid_next = rd_hit;
            out_pos_next    = rd_hit ? rdata_reg[EW-1:BW] : '0;
            out_base_next   = rd_hit ? rdata_reg[BW-1:0] : '0;
            out_upd_next    = (op_reg == sptbl_pkg::OP_INSERT) && upd_reg;
            out_drop_next   = (op_reg == sptbl_pkg::OP_INSERT) && drop_reg;
            case (op_reg)
                sptbl_pkg::OP_INSERT: out_slot_next = slot_reg;
                sptbl_pkg::OP_READ:   out_slot_next = ridx_reg;
                default:              out_slot_next = '0;
            endcase
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            entry_mem[waddr] <= wdata;
        end
        rdata_reg <= entry_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            ins_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            chk_vld_reg   <= chk_vld_next;
            ins_reg       <= ins_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        base_reg       <= base_next;
        ridx_reg       <= ridx_next;
        rd_idx_reg     <= rd_idx_next;
        chk_idx_reg    <= chk_idx_next;
        carry_reg      <= carry_next;
        slot_reg       <= slot_next;
        upd_reg        <= upd_next;
        drop_reg       <= drop_next;
        out_slot_reg   <= out_slot_next;
        out_pos_reg    <= out_pos_next;
        out_base_reg   <= out_base_next;
        out_evalid_reg <= out_evalid_next;
        out_count_reg  <= out_count_next;
        out_upd_reg    <= out_upd_next;
        out_drop_reg   <= out_drop_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_drop_reg, out_upd_reg, out_count_reg,
                       out_evalid_reg, out_base_reg, out_pos_reg, out_slot_reg};

endmodule

// ----- rtl/sptbl_check.sv -----
`include "sorted_position_table_insert_assert.svh"

module sptbl_check (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sptbl_pkg::M_TDATA_W-1:0] m_tdata
);

    // one item in work at a time
    `SPTBL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item taken early")

    `SPTBL_ASSERT_SAME(a_count_range, m_tvalid, m_tdata[38:32] <= 7'd64, "entry count above table size")

    `SPTBL_ASSERT_SAME(a_upd_xor_drop, m_tvalid, !(m_tdata[39] && m_tdata[40]), "update and drop together")

    `SPTBL_ASSERT_SAME(a_valid_below_count, m_tvalid && m_tdata[31], m_tdata[5:0] < m_tdata[38:32], "valid read at or above count")

    `SPTBL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

endmodule

bind sorted_position_table_insert sptbl_check u_sptbl_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/sorted_position_table_checker.sv -----
`timescale 1ns / 100ps

module sorted_position_table_checker
    import sptbl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatch_count,
    output int                   results_pending
);

    // packed so that slot lands in the lowest bits, as on m_tdata
    typedef struct packed {
        logic                 dropped;
        logic                 was_update;
        logic [CNT_W-1:0]     entry_count;
        logic                 entry_valid;
        logic [BASE_W-1:0]    entry_base;
        logic [POS_WIDTH-1:0] entry_position;
        logic [IDX_W-1:0]     slot;
    } table_result_t;

    logic [POS_WIDTH-1:0] table_keys [MAX_ENTRIES];
    logic [BASE_W-1:0]    table_bases [MAX_ENTRIES];
    int                   table_fill;
    table_result_t        expected_results [$];
    table_result_t        got_result;
    table_result_t        want_result;
    table_result_t        next_result;
    int                   errors;

    task automatic apply_table_op(
        input  op_t                  op,
        input  logic [POS_WIDTH-1:0] pos,
        input  logic [BASE_W-1:0]    base,
        input  logic [IDX_W-1:0]     idx,
        output table_result_t        res
    );
        int hit;
        int k;
        res = '0;
        case (op)
            OP_INSERT: begin
                hit = -1;
                for (k = 0; k < table_fill && hit < 0; k++) begin
                    if (table_keys[k] == pos)
                        hit = k;
                end
                if (hit >= 0) begin
                    table_bases[hit] = base;
                    res.slot         = IDX_W'(hit);
                    res.was_update   = 1'b1;
                end else if (table_fill >= MAX_ENTRIES) begin
                    res.dropped = 1'b1;
                end else begin
                    // ripple larger keys up by one to open the slot
                    k = table_fill;
                    while (k > 0 && pos < table_keys[k-1]) begin
                        table_keys[k]  = table_keys[k-1];
                        table_bases[k] = table_bases[k-1];
                        k--;
                    end
                    table_keys[k]  = pos;
                    table_bases[k] = base;
                    res.slot       = IDX_W'(k);
                    table_fill++;
                end
            end
            OP_READ: begin
                res.slot = idx;
                if (int'(idx) < table_fill) begin
                    res.entry_position = table_keys[idx];
                    res.entry_base     = table_bases[idx];
                    res.entry_valid    = 1'b1;
                end
            end
            OP_CLEAR: begin
                table_fill = 0;
            end
            default: begin
            end
        endcase
        res.entry_count = CNT_W'(table_fill);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            table_fill = 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_result = table_result_t'(m_tdata[M_FIELDS_W-1:0]);
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result item with nothing expected: %h", $time, m_tdata);
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result !== want_result) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: mismatch exp/got slot %0d/%0d pos %h/%h base %0d/%0d",
                                     $time,
                                     want_result.slot, got_result.slot,
                                     want_result.entry_position, got_result.entry_position,
                                     want_result.entry_base, got_result.entry_base);
                            $display("    valid %0d/%0d count %0d/%0d upd %0d/%0d drop %0d/%0d",
                                     want_result.entry_valid, got_result.entry_valid,
                                     want_result.entry_count, got_result.entry_count,
                                     want_result.was_update, got_result.was_update,
                                     want_result.dropped, got_result.dropped);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_table_op(op_t'(s_tuser),
                               s_tdata[POS_WIDTH-1:0],
                               s_tdata[POS_WIDTH+BASE_W-1:POS_WIDTH],
                               s_tdata[S_FIELDS_W-1:POS_WIDTH+BASE_W],
                               next_result);
                expected_results.push_back(next_result);
            end
        end
        mismatch_count  <= errors;
        results_pending <= expected_results.size();
    end

endmodule

// ----- verif/tb_sorted_position_table_insert.sv -----
`timescale 1ns / 100ps

module tb_sorted_position_table_insert;
    import sptbl_pkg::*;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int                   mismatch_count;
    int                   results_pending;
    int                   sender_idle   = 0;
    int                   receiver_idle = 0;
    int                   hold_cycles   = 0;
    int                   hold_len      = 0;
    int                   hold_req      = 0;
    int                   hold_ack      = 0;
    int                   items_sent    = 0;
    logic [POS_WIDTH-1:0] position_pool [$];

    sorted_position_table_insert dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_position_table_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random backpressure, or a long hold-off while hold_cycles runs down
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_cycles <= hold_len;
            m_tready    <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    task automatic send_item(
        input op_t                  op,
        input logic [POS_WIDTH-1:0] pos,
        input logic [BASE_W-1:0]    base,
        input logic [IDX_W-1:0]     idx
    );
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_FIELDS_W-1:0] = {idx, base, pos};
        while ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        if (op == OP_CLEAR) begin
            position_pool.delete();
        end else if (op == OP_INSERT) begin
            position_pool.push_back(pos);
            if (position_pool.size() > 128)
                void'(position_pool.pop_front());
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0)
            @(posedge aclk);
    endtask

    task automatic random_item();
        int                   r;
        int                   sel;
        op_t                  op;
        logic [POS_WIDTH-1:0] pos;
        r = $urandom_range(99);
        if (r < 62)
            op = OP_INSERT;
        else if (r < 92)
            op = OP_READ;
        else if (r < 96)
            op = OP_NOP;
        else
            op = OP_CLEAR;
        // reuse earlier keys to hit updates, crowd the ends of the key range
        sel = $urandom_range(99);
        if (sel < 15 && position_pool.size() > 0)
            pos = position_pool[$urandom_range(position_pool.size() - 1)];
        else if (sel < 25)
            pos = POS_WIDTH'($urandom_range(63));
        else if (sel < 30)
            pos = {POS_WIDTH{1'b1}} - POS_WIDTH'($urandom_range(63));
        else
            pos = POS_WIDTH'($urandom);
        send_item(op, pos, BASE_W'($urandom), IDX_W'($urandom));
    endtask

    // episodes of mostly inserts, often from an empty table, so it fills and overflows
    task automatic run_random(input int count);
        int target;
        int len;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(9) < 6)
                send_item(OP_CLEAR, POS_WIDTH'($urandom), BASE_W'($urandom),
                          IDX_W'($urandom));
            len = $urandom_range(20, 140);
            while (len > 0 && items_sent < target) begin
                random_item();
                len--;
            end
        end
    endtask

    initial begin
        #12_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int i;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle   = 38;
        receiver_idle = 46;

        send_item(OP_READ, '0, '0, '0);             // read on an empty table
        send_item(OP_NOP, '1, '1, '1);
        send_item(OP_INSERT, '1, 2'd3, '0);         // highest key
        send_item(OP_INSERT, '0, 2'd0, '1);         // lowest key shifts the rest up
        send_item(OP_INSERT, 23'h001000, 2'd2, '0);
        send_item(OP_INSERT, 23'h2aaaaa, 2'd1, 6'h2a);
        send_item(OP_INSERT, '0, 2'd1, 6'h15);      // update in the first slot
        send_item(OP_INSERT, '1, 2'd2, '0);         // update in the last slot
        for (i = 0; i < 5; i++)
            send_item(OP_READ, 23'h555555, 2'd3, IDX_W'(i));
        send_item(OP_READ, '0, '0, '1);             // read far beyond the count
        send_item(OP_NOP, 23'h2aaaaa, 2'd2, 6'h2a);
        send_item(OP_CLEAR, '1, '1, '1);
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_INSERT, 23'h555555, 2'd3, 6'h15);
        send_item(OP_READ, '1, '1, '0);
        send_item(OP_INSERT, 23'h555555, 2'd0, '0);
        send_item(OP_CLEAR, '0, '0, '0);

        hold_len <= 400;
        hold_req <= hold_req + 1;
        run_random(650);
        drain_results();

        sender_idle   = 46;
        receiver_idle = 38;
        run_random(650);
        drain_results();

        sender_idle   = 0;
        receiver_idle = 0;
        hold_len <= 300;
        hold_req <= hold_req + 1;
        run_random(650);
        drain_results();

        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sptbl_pkg.sv
rtl/sptbl_ctrl.sv
rtl/sptbl_dp.sv
rtl/sorted_position_table_insert.sv
rtl/sptbl_check.sv
verif/sorted_position_table_checker.sv
verif/tb_sorted_position_table_insert.sv
